/* rtl/core/yuv420_pkg.sv */
package yuv420_pkg;

    // component and arithmetic widths
    localparam int CompW    = 8;
    localparam int PixW     = 24;
    localparam int NumW     = 15;                  // numerators stay below 25600
    localparam int RecipW   = 13;
    localparam int ProdW    = NumW + RecipW;
    localparam int DivShift = 19;
    localparam int NumStages = 4;

    // divide by 100 as multiply by ceil(2^19 / 100), exact for numerators below 25600
    localparam logic [RecipW-1:0] DivRecip = 13'd5243;

    // pixel_format register codes
    localparam logic FMT_RGB888 = 1'b0;
    localparam logic FMT_RGB565 = 1'b1;

    typedef struct packed {
        logic [PixW-1:0] first_pixel;
        logic [PixW-1:0] second_pixel;
    } t_pix_in;

    typedef struct packed {
        logic [CompW-1:0] luma_first;
        logic [CompW-1:0] luma_second;
        logic [CompW-1:0] chroma_blue;
        logic [CompW-1:0] chroma_red;
    } t_yuv_out;

    typedef struct packed {
        logic [CompW-1:0] r;
        logic [CompW-1:0] g;
        logic [CompW-1:0] b;
    } t_rgb;

    // per-stage load enables and valid bits
    typedef struct packed {
        logic [NumStages-1:0] en;
        logic [NumStages-1:0] vld;
    } t_pipe_ctl;

    // split raw pixel bits into 8-bit components
    function automatic t_rgb unpack_pixel(input logic fmt, input logic [PixW-1:0] raw);
        t_rgb res;
        res = '0;
        unique case (fmt)
            FMT_RGB888: begin
                res.b = raw[7:0];
                res.g = raw[15:8];
                res.r = raw[23:16];
            end
            FMT_RGB565: begin
                res.b = {raw[7:3], 3'b000};
                res.g = {raw[2:0], raw[15:13], 2'b00};
                res.r = {raw[12:8], 3'b000};
            end
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

/* rtl/core/yuv420_pipe_ctl.sv */
module yuv420_pipe_ctl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    output logic                  o_in_ready,
    output yuv420_pkg::t_pipe_ctl o_ctl
);
    import yuv420_pkg::*;

    logic [NumStages-1:0] r_vld;
    logic [NumStages-1:0] n_vld;
    logic [NumStages-1:0] w_en;

    // a stage loads when empty or when its contents move on
    always_comb begin
        w_en[NumStages-1] = !r_vld[NumStages-1] || i_out_ready;
        for (int k = NumStages - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // valid bits follow the data
    always_comb begin
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NumStages; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready = w_en[0];
    assign o_ctl.en   = w_en;
    assign o_ctl.vld  = r_vld;

endmodule

/* rtl/core/yuv420_pix_conv.sv */
module yuv420_pix_conv (
    input  logic                              i_clk,
    input  yuv420_pkg::t_pipe_ctl             i_ctl,
    input  logic                              i_fmt,
    input  logic [yuv420_pkg::PixW-1:0]       i_raw,
    output logic [yuv420_pkg::ProdW-1:0]      o_y_prod,
    output logic [yuv420_pkg::ProdW-1:0]      o_u_prod,
    output logic [yuv420_pkg::ProdW-1:0]      o_v_prod
);
    import yuv420_pkg::*;

    t_rgb              r_rgb;
    logic [NumW-1:0]   r_y_num;
    logic [NumW-1:0]   r_u_num;
    logic [NumW-1:0]   r_v_num;
    logic [ProdW-1:0]  r_y_prod;
    logic [ProdW-1:0]  r_u_prod;
    logic [ProdW-1:0]  r_v_prod;
    logic [NumW:0]     w_y_num;
    logic [NumW:0]     w_u_num;
    logic [NumW:0]     w_v_num;

    // stage 0: unpack components
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_rgb <= unpack_pixel(i_fmt, i_raw);
        end
    end

    // weighted sums; chroma offset keeps both differences positive
    always_comb begin
        w_y_num = 16'(r_rgb.r) * 16'd30 + 16'(r_rgb.g) * 16'd59 + 16'(r_rgb.b) * 16'd11;
        w_u_num = 16'd12800 + 16'(r_rgb.b) * 16'd50
                - (16'(r_rgb.r) * 16'd17 + 16'(r_rgb.g) * 16'd33);
        w_v_num = 16'd12800 + 16'(r_rgb.r) * 16'd50
                - (16'(r_rgb.g) * 16'd42 + 16'(r_rgb.b) * 16'd8);
    end

    // stage 1: numerators
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_y_num <= w_y_num[NumW-1:0];
            r_u_num <= w_u_num[NumW-1:0];
            r_v_num <= w_v_num[NumW-1:0];
        end
    end

    // stage 2: reciprocal products for the divide by 100
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_y_prod <= ProdW'(r_y_num) * ProdW'(DivRecip);
            r_u_prod <= ProdW'(r_u_num) * ProdW'(DivRecip);
            r_v_prod <= ProdW'(r_v_num) * ProdW'(DivRecip);
        end
    end

    assign o_y_prod = r_y_prod;
    assign o_u_prod = r_u_prod;
    assign o_v_prod = r_v_prod;

endmodule

/* rtl/core/rgb_pixel_pair_to_yuv420.sv */
// RGB pixel pair to YUV 4:2:0 converter.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one word holding two
// horizontally adjacent pixels. Output channel (o_out_valid / i_out_ready /
// o_out_data) gives one word per input: the two lumas and the truncated mean of
// the pair's U and V values.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the pixel
// format: 0 = 24-bit RGB888, 1 = 16-bit RGB565 packing. o_cfg_ready is always
// high; write only while no word is in flight.
// Throughput: one pair per cycle while the receiver holds i_out_ready high,
// through the four-stage pipeline (unpack, weighted sums, reciprocal
// multiply for the divide by 100, quotient and chroma average).
// A stalled receiver holds the output word; upstream stages keep filling empty
// slots, and o_in_ready drops only once every stage holds a word.
// Reset clears all valid bits and sets the format to RGB888; payload registers
// are not reset.
module rgb_pixel_pair_to_yuv420 (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  yuv420_pkg::t_pix_in   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output yuv420_pkg::t_yuv_out  o_out_data
);
    import yuv420_pkg::*;

    logic              r_fmt;
    t_pipe_ctl         w_ctl;
    t_yuv_out          r_out;
    t_yuv_out          n_out;
    logic [ProdW-1:0]  w_y1_prod;
    logic [ProdW-1:0]  w_u1_prod;
    logic [ProdW-1:0]  w_v1_prod;
    logic [ProdW-1:0]  w_y2_prod;
    logic [ProdW-1:0]  w_u2_prod;
    logic [ProdW-1:0]  w_v2_prod;
    logic [CompW:0]    w_u_sum;
    logic [CompW:0]    w_v_sum;

    // format register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_RGB888;
        end else if (i_cfg_valid) begin
            r_fmt <= i_cfg_data;
        end
    end

    // handshake and stage enables
    yuv420_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_ctl       (w_ctl)
    );

    // per-pixel conversion pipes
    yuv420_pix_conv u_conv_first (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_fmt    (r_fmt),
        .i_raw    (i_in_data.first_pixel),
        .o_y_prod (w_y1_prod),
        .o_u_prod (w_u1_prod),
        .o_v_prod (w_v1_prod)
    );

    yuv420_pix_conv u_conv_second (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_fmt    (r_fmt),
        .i_raw    (i_in_data.second_pixel),
        .o_y_prod (w_y2_prod),
        .o_u_prod (w_u2_prod),
        .o_v_prod (w_v2_prod)
    );

    // quotients and chroma average
    always_comb begin
        w_u_sum = {1'b0, w_u1_prod[DivShift +: CompW]} + {1'b0, w_u2_prod[DivShift +: CompW]};
        w_v_sum = {1'b0, w_v1_prod[DivShift +: CompW]} + {1'b0, w_v2_prod[DivShift +: CompW]};
        n_out.luma_first  = w_y1_prod[DivShift +: CompW];
        n_out.luma_second = w_y2_prod[DivShift +: CompW];
        n_out.chroma_blue = w_u_sum[CompW:1];
        n_out.chroma_red  = w_v_sum[CompW:1];
    end

    // stage 3: output register
    always_ff @(posedge i_clk) begin
        if (w_ctl.en[NumStages-1]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = w_ctl.vld[NumStages-1];
    assign o_out_data  = r_out;

    // an empty output stage never blocks the input
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    // input blocks only when every stage holds a word and the receiver stalls
    a_stall_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (w_ctl.vld == {NumStages{1'b1}}) && !i_out_ready)
        else $error("input stalled with room in the pipeline");

    // a new output word comes only from the stage before it
    a_out_from_pipe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_ctl.vld[NumStages-2]))
        else $error("output word without a source");

endmodule
